// File: design/rv32crt_pkg.sv
// Shared types and codes for the RV32 constant-register tracker.
// Stream payload layouts, action, class and ALU operation codes, FSM states.
// No dependencies.
`default_nettype none

package rv32crt_pkg;

    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 40;

    // action codes (carried on s_tuser)
    localparam logic [2:0] ACT_EXECUTE     = 3'd0;
    localparam logic [2:0] ACT_MERGE       = 3'd1;
    localparam logic [2:0] ACT_SET_ZERO    = 3'd2;
    localparam logic [2:0] ACT_SET_UNKNOWN = 3'd3;
    localparam logic [2:0] ACT_READ        = 3'd4;

    // instruction classes
    localparam logic [2:0] CLS_ALU  = 3'd0;
    localparam logic [2:0] CLS_CSR  = 3'd1;
    localparam logic [2:0] CLS_JUMP = 3'd2;
    localparam logic [2:0] CLS_LOAD = 3'd3;
    localparam logic [2:0] CLS_NONE = 3'd4;

    // ALU operations
    localparam logic [4:0] OP_LUI   = 5'd0;
    localparam logic [4:0] OP_ADDI  = 5'd1;
    localparam logic [4:0] OP_SLTI  = 5'd2;
    localparam logic [4:0] OP_SLTIU = 5'd3;
    localparam logic [4:0] OP_XORI  = 5'd4;
    localparam logic [4:0] OP_ORI   = 5'd5;
    localparam logic [4:0] OP_ANDI  = 5'd6;
    localparam logic [4:0] OP_SLLI  = 5'd7;
    localparam logic [4:0] OP_SRLI  = 5'd8;
    localparam logic [4:0] OP_SRAI  = 5'd9;
    localparam logic [4:0] OP_ADD   = 5'd10;
    localparam logic [4:0] OP_SUB   = 5'd11;
    localparam logic [4:0] OP_SLL   = 5'd12;
    localparam logic [4:0] OP_SLT   = 5'd13;
    localparam logic [4:0] OP_SLTU  = 5'd14;
    localparam logic [4:0] OP_XOR   = 5'd15;
    localparam logic [4:0] OP_SRL   = 5'd16;
    localparam logic [4:0] OP_SRA   = 5'd17;
    localparam logic [4:0] OP_OR    = 5'd18;
    localparam logic [4:0] OP_AND   = 5'd19;
    localparam logic [4:0] OP_UNSUP = 5'd20;

    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] incoming_value;
        logic        incoming_known;
        logic [4:0]  reg_select;
        logic [19:0] immediate;
        logic [4:0]  src2_index;
        logic [4:0]  src1_index;
        logic [4:0]  dest_index;
        logic [4:0]  alu_op;
        logic [2:0]  op_class;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic        merge_changed;
        logic        wrote_register;
        logic [31:0] result_value;
        logic        result_known;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

`default_nettype wire

// File: design/rv32_constant_register_tracker_top.sv
// Top level of the RV32 constant-register tracker: value memory, known flags,
// shared ALU and the output register.
// Depends on rv32crt_pkg.
`default_nettype none

//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------------------
//  s_      | in        | s_tvalid/s_tready| s_tuser action, s_tdata instruction/merge
//  m_      | out       | m_tvalid/m_tready| m_tdata known, value, wrote, changed
//
//  Each transaction first reads the value memory (two read ports, registered
//  data), then in ST_EXEC evaluates, writes back and loads the output
//  register. The next transaction is taken while a result waits on m_.
//  An item stalls in ST_EXEC while the output register is full.
//  Reset clears the known flags (x0 known) and the per-entry valid bits at once;
//  an entry not valid reads as zero, so no clearing pass runs.

module rv32_constant_register_tracker_top #(
    parameter int REG_COUNT = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] op_class, [7:3] alu_op, [12:8] dest_index, [17:13] src1_index,
    // [22:18] src2_index, [42:23] immediate, [47:43] reg_select,
    // [48] incoming_known, [80:49] incoming_value, [87:81] zero
    input  wire logic [rv32crt_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] action
    input  wire logic [rv32crt_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] result_known, [32:1] result_value, [33] wrote_register,
    // [34] merge_changed, [39:35] zero
    output logic [rv32crt_pkg::M_TDATA_W-1:0]      m_tdata
);
    import rv32crt_pkg::*;

    localparam int         IDX_W     = $clog2(REG_COUNT);
    localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

    // register number is a real entry of the file
    function automatic logic in_range(input logic [4:0] r);
        return {1'b0, r} < REG_LIMIT;
    endfunction

    state_t                state_reg, state_next;
    in_item_t              item_reg;
    logic [2:0]            action_reg;
    logic [REG_COUNT-1:0]  known_reg, known_next;
    logic [REG_COUNT-1:0]  valid_reg, valid_next;
    logic [31:0]           value_mem [REG_COUNT];
    logic [31:0]           rdata_a_reg, rdata_b_reg;
    out_item_t             out_reg, out_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    in_item_t              s_item;
    logic                  accept;
    logic [4:0]            rd_addr_a;
    logic                  finish;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [31:0]           wr_data;

    assign s_item    = in_item_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign rd_addr_a = (s_tuser == ACT_EXECUTE) ? s_item.src1_index : s_item.reg_select;
    assign finish    = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_TDATA_W'(out_reg);

    // value memory: two synchronous read ports, one write port
    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_a_reg <= value_mem[rd_addr_a[IDX_W-1:0]];
            rdata_b_reg <= value_mem[s_item.src2_index[IDX_W-1:0]];
        end
        if (wr_en) begin
            value_mem[wr_idx] <= wr_data;
        end
    end

    // item holding register
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg   <= s_item;
            action_reg <= s_tuser;
        end
    end

    // evaluate the held item against the read data
    always_comb begin
        logic             a_known, b_known, alu_known, wr_ok, k_after;
        logic [IDX_W-1:0] a_idx, b_idx, rd_idx;
        logic [31:0]      a_val, b_val, opb, alu_res, sext_imm;
        logic [4:0]       sh;
        logic [4:0]       op;

        state_next    = state_reg;
        known_next    = known_reg;
        valid_next    = valid_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        wr_en         = 1'b0;
        wr_data       = '0;

        op     = item_reg.alu_op;
        a_idx  = (action_reg == ACT_EXECUTE) ? item_reg.src1_index[IDX_W-1:0]
                                             : item_reg.reg_select[IDX_W-1:0];
        b_idx  = item_reg.src2_index[IDX_W-1:0];
        rd_idx = item_reg.dest_index[IDX_W-1:0];
        wr_idx = rd_idx;

        a_known = ((action_reg == ACT_EXECUTE) ? in_range(item_reg.src1_index)
                                               : in_range(item_reg.reg_select))
                  && known_reg[a_idx];
        b_known = in_range(item_reg.src2_index) && known_reg[b_idx];
        a_val   = valid_reg[a_idx] ? rdata_a_reg : 32'd0;
        b_val   = valid_reg[b_idx] ? rdata_b_reg : 32'd0;

        sext_imm = {{20{item_reg.immediate[11]}}, item_reg.immediate[11:0]};
        opb      = (op <= OP_SRAI) ? sext_imm : b_val;
        sh       = (op <= OP_SRAI) ? item_reg.immediate[4:0] : b_val[4:0];

        case (op) inside
            OP_ADDI, OP_ADD:            alu_res = a_val + opb;
            OP_SUB:                     alu_res = a_val - opb;
            OP_SLTI, OP_SLT:            alu_res = {31'd0, $signed(a_val) < $signed(opb)};
            OP_SLTIU, OP_SLTU:          alu_res = {31'd0, a_val < opb};
            OP_XORI, OP_XOR:            alu_res = a_val ^ opb;
            OP_ORI, OP_OR:              alu_res = a_val | opb;
            OP_ANDI, OP_AND:            alu_res = a_val & opb;
            OP_SLLI, OP_SLL:            alu_res = a_val << sh;
            OP_SRLI, OP_SRL:            alu_res = a_val >> sh;
            OP_SRAI, OP_SRA:            alu_res = 32'($signed(a_val) >>> sh);
            default:                    alu_res = {item_reg.immediate, 12'd0};
        endcase

        // known result: lui needs nothing, I-forms need src1, R-forms both
        if (op == OP_LUI) begin
            alu_known = 1'b1;
        end else if (op >= OP_UNSUP) begin
            alu_known = 1'b0;
        end else if (op <= OP_SRAI) begin
            alu_known = a_known;
        end else begin
            alu_known = a_known && b_known;
        end

        wr_ok   = (item_reg.op_class <= CLS_LOAD) && (item_reg.dest_index != 5'd0)
                  && in_range(item_reg.dest_index);
        k_after = 1'b0;

        if (finish) begin
            out_next      = '0;
            m_tvalid_next = 1'b1;
            state_next    = ST_IDLE;
            case (action_reg)
                ACT_EXECUTE: begin
                    if (wr_ok) begin
                        k_after = (item_reg.op_class == CLS_ALU) && alu_known;
                        known_next[rd_idx]      = k_after;
                        valid_next[rd_idx]      = 1'b1;
                        wr_en                   = 1'b1;
                        wr_data                 = k_after ? alu_res : 32'd0;
                        out_next.result_known   = k_after;
                        out_next.result_value   = k_after ? alu_res : 32'd0;
                        out_next.wrote_register = 1'b1;
                    end
                end
                ACT_MERGE: begin
                    k_after = a_known;
                    // drop a known entry to unknown when the incoming value is unknown or disagrees
                    if (a_known && (item_reg.reg_select != 5'd0) &&
                        (!item_reg.incoming_known || item_reg.incoming_value != a_val)) begin
                        known_next[a_idx]      = 1'b0;
                        valid_next[a_idx]      = 1'b0;
                        k_after                = 1'b0;
                        out_next.merge_changed = 1'b1;
                    end
                    out_next.result_known = k_after;
                    out_next.result_value = k_after ? a_val : 32'd0;
                end
                ACT_SET_ZERO: begin
                    known_next = '1;
                    valid_next = '0;
                end
                ACT_SET_UNKNOWN: begin
                    known_next    = '0;
                    known_next[0] = 1'b1;
                    valid_next    = '0;
                end
                ACT_READ: begin
                    out_next.result_known = a_known;
                    out_next.result_value = a_known ? a_val : 32'd0;
                end
                default: begin
                    out_next = '0;
                end
            endcase
        end else if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (accept) begin
            state_next = ST_EXEC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            known_reg     <= REG_COUNT'(1);
            valid_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            known_reg     <= known_next;
            valid_reg     <= valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // hold the result payload until taken
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire
